@@ src/nswe_pkg.sv @@
// ----------------------------------------------------------------------------
// nswe_pkg: navigation subframe word encoder shared definitions
// Timing constants, reciprocal multipliers, BCH(15,11) rows and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package nswe_pkg;

    // frame layout
    localparam logic [10:0] PREAMBLE = 11'h712;
    localparam logic [29:0] WEEK_MS  = 30'd604800000;
    localparam logic [3:0]  LAST_POS = 4'd9;

    // svid ranges for D1 timing, zero is unsupported
    localparam logic [5:0] SVID_NONE   = 6'd0;
    localparam logic [5:0] SVID_D1_MIN = 6'd6;
    localparam logic [5:0] SVID_D1_MAX = 6'd58;

    // reciprocal division of a 27-bit value x = ms >> 3
    localparam int X_W    = 27;
    localparam int MULT_W = 28;
    localparam int PROD_W = 57;
    localparam int Q_W    = 20;

    localparam int SH_125 = 34;
    localparam int SH_375 = 36;
    localparam int SH_750 = 37;
    localparam int SH_75  = 34;

    localparam logic [63:0] M125_FULL = ((64'd1 << SH_125) + 64'd124) / 64'd125;
    localparam logic [63:0] M375_FULL = ((64'd1 << SH_375) + 64'd374) / 64'd375;
    localparam logic [63:0] M750_FULL = ((64'd1 << SH_750) + 64'd749) / 64'd750;
    localparam logic [63:0] M75_FULL  = ((64'd1 << SH_75) + 64'd74) / 64'd75;

    localparam logic [MULT_W-1:0] M125 = M125_FULL[MULT_W-1:0];
    localparam logic [MULT_W-1:0] M375 = M375_FULL[MULT_W-1:0];
    localparam logic [MULT_W-1:0] M750 = M750_FULL[MULT_W-1:0];
    localparam logic [MULT_W-1:0] M75  = M75_FULL[MULT_W-1:0];

    // BCH(15,11) parity check rows
    localparam logic [14:0] BCH_ROW0 = 15'h7ac0;
    localparam logic [14:0] BCH_ROW1 = 15'h3d60;
    localparam logic [14:0] BCH_ROW2 = 15'h1eb0;
    localparam logic [14:0] BCH_ROW3 = 15'h7590;

    // per-beat control carried down the pipeline
    typedef struct packed {
        logic header;
        logic bad;
        logic d1;
        logic merge;
        logic last;
    } ctrl_t;

    // four parity bits for eleven information bits
    function automatic logic [3:0] bch_parity(input logic [10:0] info);
        logic [14:0] v;
        logic [3:0]  p;
        v    = {info, 4'b0000};
        p[3] = ^(v & BCH_ROW0);
        p[2] = ^(v & BCH_ROW1);
        p[1] = ^(v & BCH_ROW2);
        p[0] = ^(v & BCH_ROW3);
        return p;
    endfunction

    // two codewords sent alternately, first codeword first
    function automatic logic [29:0] interleave(input logic [14:0] c1,
                                               input logic [14:0] c2);
        logic [29:0] w;
        w = '0;
        for (int k = 0; k < 15; k++) begin
            w[29-2*k] = c1[14-k];
            w[28-2*k] = c2[14-k];
        end
        return w;
    endfunction

    // remainder by five, using 16 = 1 (mod 5) to fold nibbles
    function automatic logic [2:0] mod5(input logic [Q_W-1:0] q);
        logic [6:0] s1;
        logic [4:0] s2;
        logic [4:0] r;
        s1 = 7'(q[3:0]) + 7'(q[7:4]) + 7'(q[11:8]) + 7'(q[15:12]) + 7'(q[19:16]);
        s2 = 5'(s1[6:4]) + 5'(s1[3:0]);
        priority if (s2 >= 5'd20) begin
            r = s2 - 5'd20;
        end else if (s2 >= 5'd15) begin
            r = s2 - 5'd15;
        end else if (s2 >= 5'd10) begin
            r = s2 - 5'd10;
        end else if (s2 >= 5'd5) begin
            r = s2 - 5'd5;
        end else begin
            r = s2;
        end
        return r[2:0];
    endfunction

endpackage

`default_nettype wire

@@ src/nav_subframe_word_encoder_top.sv @@
// ----------------------------------------------------------------------------
// nav_subframe_word_encoder_top: navigation subframe word encoder
// Header beats give word 1 (preamble, subframe, seconds), or an all-zero
// word flagged bad for svid zero; data beats give interleaved BCH(15,11)
// coded words with seconds merged into word 2. Stages: input register, week
// reduction, reciprocal multiply, coding into the output register.
// Throughput: one beat per cycle; each stage holds one beat and moves on
// whenever the stage after it frees up, so only result stalls slow the input.
// Reset clears all valid flags, the word position and the stored seconds.
// ----------------------------------------------------------------------------
`default_nettype none

module nav_subframe_word_encoder_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_header,
    input  wire logic [5:0]  s_svid,
    input  wire logic [29:0] s_time_ms,
    input  wire logic [21:0] s_data_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [29:0]      m_coded_word,
    output logic             m_last_word,
    output logic             m_bad_svid
);

    // pipeline flow control
    logic v0_reg, v1_reg, v2_reg, mv_reg;
    logic v0_next, v1_next, v2_next, mv_next;
    logic load_out, load2, load1, s_beat;

    assign load_out = !mv_reg || m_ready;
    assign load2    = !v2_reg || load_out;
    assign load1    = !v1_reg || load2;
    assign s_ready  = !v0_reg || load1;
    assign s_beat   = s_valid && s_ready;

    assign v0_next = s_ready ? s_valid : v0_reg;
    assign v1_next = load1 ? v0_reg : v1_reg;
    assign v2_next = load2 ? v1_reg : v2_reg;
    assign mv_next = load_out ? v2_reg : mv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            mv_reg <= mv_next;
        end
    end

    // word position tracking at the input beat
    logic [3:0]     wp_reg, wp_next;
    nswe_pkg::ctrl_t in_ctrl;

    always_comb begin
        in_ctrl.header = s_header;
        in_ctrl.bad    = s_header && (s_svid == nswe_pkg::SVID_NONE);
        in_ctrl.d1     = (s_svid >= nswe_pkg::SVID_D1_MIN) &&
                         (s_svid <= nswe_pkg::SVID_D1_MAX);
        in_ctrl.merge  = !s_header && (wp_reg == 4'd1);
        in_ctrl.last   = !s_header && (wp_reg >= nswe_pkg::LAST_POS);
        wp_next        = wp_reg;
        if (s_beat) begin
            if (s_header) begin
                wp_next = in_ctrl.bad ? 4'd0 : 4'd1;
            end else if (wp_reg != 4'd0) begin
                wp_next = (wp_reg >= nswe_pkg::LAST_POS) ? 4'd0 : wp_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 4'd0;
        end else begin
            wp_reg <= wp_next;
        end
    end

    // stage 0: input register
    nswe_pkg::ctrl_t p0_ctrl_reg;
    logic [29:0]     p0_ms_reg;
    logic [21:0]     p0_data_reg;

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            p0_ctrl_reg <= in_ctrl;
            p0_ms_reg   <= s_time_ms;
            p0_data_reg <= s_data_word;
        end
    end

    // stage 1: reduce time into one week
    nswe_pkg::ctrl_t p1_ctrl_reg;
    logic [29:0]     p1_ms_reg;
    logic [21:0]     p1_data_reg;
    logic [29:0]     ms_mod;

    assign ms_mod = (p0_ms_reg >= nswe_pkg::WEEK_MS) ? p0_ms_reg - nswe_pkg::WEEK_MS
                                                     : p0_ms_reg;

    always_ff @(posedge aclk) begin
        if (load1) begin
            p1_ctrl_reg <= p0_ctrl_reg;
            p1_ms_reg   <= ms_mod;
            p1_data_reg <= p0_data_reg;
        end
    end

    // stage 2: reciprocal multiplies for seconds and subframe quotients
    nswe_pkg::ctrl_t                p2_ctrl_reg;
    logic [21:0]                    p2_data_reg;
    logic [nswe_pkg::Q_W-1:0]       sow_q_reg, sub_q_reg;
    logic [nswe_pkg::X_W-1:0]       x_val;
    logic [nswe_pkg::MULT_W-1:0]    sow_mult, sub_mult;
    logic [nswe_pkg::PROD_W-1:0]    sow_prod, sub_prod;
    logic [nswe_pkg::Q_W-1:0]       sow_q, sub_q;

    always_comb begin
        x_val    = p1_ms_reg[29:3];
        sow_mult = p1_ctrl_reg.d1 ? nswe_pkg::M125 : nswe_pkg::M375;
        sub_mult = p1_ctrl_reg.d1 ? nswe_pkg::M750 : nswe_pkg::M75;
        sow_prod = nswe_pkg::PROD_W'(x_val) * nswe_pkg::PROD_W'(sow_mult);
        sub_prod = nswe_pkg::PROD_W'(x_val) * nswe_pkg::PROD_W'(sub_mult);
        sow_q    = p1_ctrl_reg.d1 ? sow_prod[nswe_pkg::SH_125 +: nswe_pkg::Q_W]
                                  : sow_prod[nswe_pkg::SH_375 +: nswe_pkg::Q_W];
        sub_q    = p1_ctrl_reg.d1 ? sub_prod[nswe_pkg::SH_750 +: nswe_pkg::Q_W]
                                  : sub_prod[nswe_pkg::SH_75 +: nswe_pkg::Q_W];
    end

    always_ff @(posedge aclk) begin
        if (load2) begin
            p2_ctrl_reg <= p1_ctrl_reg;
            p2_data_reg <= p1_data_reg;
            sow_q_reg   <= sow_q;
            sub_q_reg   <= sub_q;
        end
    end

    // stage 3: build word 1 or code a data word
    logic [11:0] sec_low_reg, sec_low_next;
    logic [19:0] sow_full;
    logic [2:0]  sub_num;
    logic [10:0] hdr_info;
    logic [29:0] hdr_word;
    logic [21:0] merged;
    logic [14:0] cw1, cw2;
    logic [29:0] data_word_coded;
    logic [29:0] coded;

    always_comb begin
        sow_full = p2_ctrl_reg.d1 ? sow_q_reg : sow_q_reg + {sow_q_reg[18:0], 1'b0};
        sub_num  = nswe_pkg::mod5(sub_q_reg) + 3'd1;
        hdr_info = {sub_num, sow_full[19:12]};
        hdr_word = {nswe_pkg::PREAMBLE, 4'b0000, hdr_info, nswe_pkg::bch_parity(hdr_info)};
        merged   = p2_ctrl_reg.merge ? (p2_data_reg | {sec_low_reg, 10'd0}) : p2_data_reg;
        cw1      = {merged[21:11], nswe_pkg::bch_parity(merged[21:11])};
        cw2      = {merged[10:0], nswe_pkg::bch_parity(merged[10:0])};
        data_word_coded = nswe_pkg::interleave(cw1, cw2);
        priority if (p2_ctrl_reg.bad) begin
            coded = '0;
        end else if (p2_ctrl_reg.header) begin
            coded = hdr_word;
        end else begin
            coded = data_word_coded;
        end
        sec_low_next = sec_low_reg;
        if (v2_reg && load_out && p2_ctrl_reg.header && !p2_ctrl_reg.bad) begin
            sec_low_next = sow_full[11:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_low_reg <= 12'd0;
        end else begin
            sec_low_reg <= sec_low_next;
        end
    end

    // output register
    logic [29:0] coded_reg;
    logic        last_reg, bad_reg;

    always_ff @(posedge aclk) begin
        if (load_out) begin
            coded_reg <= coded;
            last_reg  <= p2_ctrl_reg.last;
            bad_reg   <= p2_ctrl_reg.bad;
        end
    end

    assign m_valid      = mv_reg;
    assign m_coded_word = coded_reg;
    assign m_last_word  = last_reg;
    assign m_bad_svid   = bad_reg;

    // checks
    a_bad_word_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_svid) |-> (m_coded_word == '0 && !m_last_word))
        else $error("bad svid beat carries a nonzero word or last flag");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg <= nswe_pkg::LAST_POS)
        else $error("word position out of range");

    a_bad_hdr_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && s_header && s_svid == nswe_pkg::SVID_NONE) |=> (wp_reg == 4'd0))
        else $error("unsupported header did not return to idle");

    a_last_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_beat && !s_header && wp_reg == nswe_pkg::LAST_POS) |=> (wp_reg == 4'd0))
        else $error("tenth word did not end the subframe");

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: nav_subframe_word_encoder_top self-checking bench
// Builds a list of header and data beats, drives them with random gaps and
// random result stalls, and checks every result beat against an in-bench
// subframe word coder that tracks the word position and stored seconds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    // frame constants
    localparam logic [31:0] WEEK_MS   = 32'd604800000;
    localparam logic [31:0] PREAMBLE  = 32'h712;
    localparam logic [3:0]  IDLE_POS  = 4'd0;
    localparam logic [3:0]  FIRST_POS = 4'd1;
    localparam logic [3:0]  LAST_POS  = 4'd9;
    localparam logic [3:0][14:0] BCH_ROWS = {15'h7ac0, 15'h3d60, 15'h1eb0, 15'h7590};
    localparam int          RANDOM_ITEMS = 1000;

    typedef struct packed {
        logic        header;
        logic [5:0]  svid;
        logic [29:0] time_ms;
        logic [21:0] data_word;
        logic        drain;
    } nav_item_t;

    typedef struct packed {
        logic [29:0] coded_word;
        logic        last_word;
        logic        bad_svid;
    } nav_word_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_header    = 1'b0;
    logic [5:0]  s_svid      = '0;
    logic [29:0] s_time_ms   = '0;
    logic [21:0] s_data_word = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [29:0] m_coded_word;
    logic        m_last_word;
    logic        m_bad_svid;

    nav_item_t pending_items[$];
    nav_word_t coded_words[$];

    // subframe coder state
    logic [3:0]  word_pos = IDLE_POS;
    logic [11:0] sec_low  = '0;

    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;
    int   errors = 0;
    int   total_items = 0;
    int   accepted_beats = 0;
    int   sent_beats = 0;
    int   recv_beats = 0;
    int   send_gap = 0;
    int   recv_stall = 0;

    nav_subframe_word_encoder_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_header     (s_header),
        .s_svid       (s_svid),
        .s_time_ms    (s_time_ms),
        .s_data_word  (s_data_word),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_coded_word (m_coded_word),
        .m_last_word  (m_last_word),
        .m_bad_svid   (m_bad_svid)
    );

    always #5 aclk = ~aclk;

    // four parity bits into the low nibble, rows applied in order
    function automatic logic [14:0] bch_encode(input logic [14:0] w);
        for (int i = 0; i < 4; i++) begin
            if (^(w & BCH_ROWS[3-i])) begin
                w[3-i] = ~w[3-i];
            end
        end
        return w;
    endfunction

    // first codeword on the odd bit positions, msb first
    function automatic logic [29:0] interleave_words(input logic [14:0] a,
                                                     input logic [14:0] b);
        logic [29:0] w;
        w = '0;
        for (int k = 0; k < 15; k++) begin
            w[29-2*k] = a[14-k];
            w[28-2*k] = b[14-k];
        end
        return w;
    endfunction

    // coded word for one accepted beat, advances the subframe state
    function automatic nav_word_t encode_nav_item(input nav_item_t it);
        nav_word_t   r;
        logic [31:0] ms;
        logic [31:0] sow;
        logic [31:0] sub;
        logic [31:0] w;
        logic [31:0] s;
        r = '0;
        if (it.header) begin
            if (it.svid == 6'd0) begin
                r.bad_svid = 1'b1;
                word_pos = IDLE_POS;
            end else begin
                ms = 32'(it.time_ms) % WEEK_MS;
                if (it.svid >= 6'd6 && it.svid <= 6'd58) begin
                    sow = ms / 32'd1000;
                    sub = (sow / 32'd6) % 32'd5 + 32'd1;
                end else begin
                    sow = (ms / 32'd3000) * 32'd3;
                    sub = (ms / 32'd600) % 32'd5 + 32'd1;
                end
                w = (PREAMBLE << 19) | (sub << 12) | ((sow >> 8) & 32'hff0);
                r.coded_word = {w[29:15], bch_encode(w[14:0])};
                sec_low = sow[11:0];
                word_pos = FIRST_POS;
            end
        end else begin
            s = 32'(it.data_word);
            if (word_pos == FIRST_POS) begin
                s = s | (32'(sec_low) << 10);
            end
            r.coded_word = interleave_words(bch_encode(15'((s >> 7) & 32'h7ff0)),
                                            bch_encode(15'((s << 4) & 32'h7ff0)));
            if (word_pos != IDLE_POS) begin
                if (word_pos >= LAST_POS) begin
                    r.last_word = 1'b1;
                    word_pos = IDLE_POS;
                end else begin
                    word_pos = word_pos + 4'd1;
                end
            end
        end
        return r;
    endfunction

    // wait cycles per beat, with regular stretches of none
    function automatic int draw_wait(input int n);
        if (n % 160 < 40) begin
            return 0;
        end
        return $urandom_range(0, 6);
    endfunction

    task automatic add_header(input logic [5:0] sv, input logic [29:0] t,
                              input logic drain);
        nav_item_t it;
        it.header    = 1'b1;
        it.svid      = sv;
        it.time_ms   = t;
        it.data_word = 22'($urandom);
        it.drain     = drain;
        pending_items.push_back(it);
    endtask

    task automatic add_data(input logic [21:0] d);
        nav_item_t it;
        it.header    = 1'b0;
        it.svid      = 6'($urandom);
        it.time_ms   = 30'($urandom);
        it.data_word = d;
        it.drain     = 1'b0;
        pending_items.push_back(it);
    endtask

    function automatic logic [29:0] rand_time();
        if ($urandom_range(0, 15) == 0) begin
            return 30'($urandom_range(32'd604800000, 32'h3fffffff));
        end
        return 30'($urandom_range(0, 32'd604799999));
    endfunction

    function automatic logic [21:0] rand_data();
        case ($urandom_range(0, 15))
            0: return 22'h3fffff;
            1: return 22'h000000;
            default: return 22'($urandom);
        endcase
    endfunction

    // input driver: one beat per pending item
    always @(negedge aclk) begin
        nav_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !in_fire)) begin
            if (s_valid) begin
                send_gap = draw_wait(sent_beats);
            end
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].drain && coded_words.size() != 0)) begin
                it = pending_items.pop_front();
                s_header    <= it.header;
                s_svid      <= it.svid;
                s_time_ms   <= it.time_ms;
                s_data_word <= it.data_word;
                s_valid     <= 1'b1;
                sent_beats++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (out_fire) begin
                recv_beats++;
                recv_stall = draw_wait(recv_beats + 80);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor: check result beats, then queue the coding of accepted beats
    always @(posedge aclk) begin
        nav_word_t want;
        nav_item_t got_in;
        in_fire  <= aresetn && s_valid && s_ready;
        out_fire <= aresetn && m_valid && m_ready;
        if (aresetn && m_valid && m_ready) begin
            if (coded_words.size() == 0) begin
                $error("unexpected result beat: coded_word %h", m_coded_word);
                errors++;
            end else begin
                want = coded_words.pop_front();
                if (m_coded_word !== want.coded_word) begin
                    $error("coded_word: expected %h, got %h", want.coded_word, m_coded_word);
                    errors++;
                end
                if (m_last_word !== want.last_word) begin
                    $error("last_word: expected %b, got %b", want.last_word, m_last_word);
                    errors++;
                end
                if (m_bad_svid !== want.bad_svid) begin
                    $error("bad_svid: expected %b, got %b", want.bad_svid, m_bad_svid);
                    errors++;
                end
            end
        end
        if (aresetn && s_valid && s_ready) begin
            got_in.header    = s_header;
            got_in.svid      = s_svid;
            got_in.time_ms   = s_time_ms;
            got_in.data_word = s_data_word;
            got_in.drain     = 1'b0;
            coded_words.push_back(encode_nav_item(got_in));
            accepted_beats++;
        end
    end

    // stimulus and end of run
    initial begin
        int pick;
        int target;
        // data while idle, unsupported satellite
        add_data(22'h3fffff);
        add_data(22'h000000);
        add_header(6'd0, 30'h3fffffff, 1'b0);
        // full D1 subframe at the start of the week
        add_header(6'd6, 30'd0, 1'b0);
        add_data(22'h3fffff);
        repeat (7) add_data(22'($urandom));
        add_data(22'h000000);
        // D2 at the end of the week, then a restart mid-subframe
        add_header(6'd1, 30'd604799999, 1'b1);
        add_data(22'($urandom));
        add_header(6'd58, 30'h3fffffff, 1'b0);
        add_data(22'h155555);
        add_data(22'h2aaaaa);
        add_header(6'd5, 30'd604800000, 1'b0);
        add_header(6'd59, 30'd599999, 1'b0);
        add_header(6'd63, 30'd123456789, 1'b0);
        // unsupported satellite mid-subframe returns to idle
        add_header(6'd0, 30'd0, 1'b0);
        add_data(22'h3fffff);

        target = pending_items.size() + RANDOM_ITEMS;
        while (pending_items.size() < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                add_header(6'($urandom_range(1, 63)), rand_time(),
                           $urandom_range(0, 24) == 0);
                repeat (9) add_data(rand_data());
            end else if (pick < 88) begin
                add_header(6'($urandom_range(0, 63)), rand_time(), 1'b0);
                repeat ($urandom_range(0, 12)) add_data(rand_data());
            end else if (pick < 94) begin
                add_header(6'd0, rand_time(), 1'b0);
                repeat ($urandom_range(0, 3)) add_data(rand_data());
            end else begin
                repeat ($urandom_range(1, 4)) add_data(rand_data());
            end
        end
        total_items = pending_items.size();

        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        while (accepted_beats != total_items) @(negedge aclk);
        while (coded_words.size() != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
        if (errors == 0) begin
            $display("nav_subframe_word_encoder_top test passed");
        end else begin
            $display("nav_subframe_word_encoder_top test failed");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("nav_subframe_word_encoder_top test failed");
        $finish;
    end

endmodule
